// ===== rtl/core/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared sizes, codes and state encoding for the slab free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

  // Sizes of the slab store.
  localparam int MAX_SLABS = 16;
  localparam int MAX_SLOTS = 64;

  localparam int SLAB_W = $clog2(MAX_SLABS);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int OPEN_W = $clog2(MAX_SLABS + 1);
  localparam int ADDR_W = SLAB_W + SLOT_W;
  localparam int CFG_W  = 7;
  localparam int STAT_W = 3;

  // Register value after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  // Request commands.
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_DISCARD = 2'd2
  } cmd_t;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_ALLOCATED  = 3'd0,
    STAT_ALLOC_FAIL = 3'd1,
    STAT_FREED      = 3'd2,
    STAT_IGNORED    = 3'd3,
    STAT_RESET_DONE = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_READ,
    S_POP
  } state_t;

endpackage

// ===== rtl/core/sfla_if.sv =====
// ----------------------------------------------------------------------------
// sfla_if
// Valid/ready channels of the slab free-list allocator: request, response
// and configuration write.
// ----------------------------------------------------------------------------

// Request channel: one command per transaction.
interface sfla_req_if;
  import sfla_pkg::*;
  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [SLAB_W-1:0] free_slab;
  logic [SLOT_W-1:0] free_slot;
  modport source (output valid, cmd, free_slab, free_slot, input ready);
  modport sink   (input valid, cmd, free_slab, free_slot, output ready);
endinterface

// Response channel: one result per request.
interface sfla_rsp_if;
  import sfla_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLAB_W-1:0] slab_index;
  logic [SLOT_W-1:0] slot_index;
  logic [CNT_W-1:0]  slab_free_left;
  modport source (output valid, status, slab_index, slot_index, slab_free_left,
                  input ready);
  modport sink   (input valid, status, slab_index, slot_index, slab_free_left,
                  output ready);
endinterface

// Configuration write channel for the slot count register.
interface sfla_cfg_if;
  import sfla_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] slots_per_slab;
  modport source (output valid, slots_per_slab, input ready);
  modport sink   (input valid, slots_per_slab, output ready);
endinterface

// ===== rtl/core/slab_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// slab_free_list_allocator
// Fixed-size object allocator over up to MAX_SLABS slabs, each with a LIFO
// free list held in a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: allocate, free (free_slab,
//   free_slot) or discard all slabs. rsp returns exactly one result per
//   request, in order. cfg writes slots_per_slab; it is taken at any time
//   and should change only while the block is idle.
// Steps (from the accepting edge to the result in the output register):
//   free, discard, unknown command, failed allocate: the execute step only.
//   allocate from an open slab: link memory read, then pop.
//   allocate that opens a slab: a link memory sweep that writes one link
//   per cycle over the effective slot count, then a link read and the pop.
//   One request is in flight at a time; the next is taken once the current
//   one has left for the output register.
// Reset: the output register is emptied and slab 0 is opened by a sweep
//   over all MAX_SLOTS of its links, during which req.ready stays low.
// Stall: a held result keeps the output register; a request taken meanwhile
//   waits before its first step, and an allocation again before its pop,
//   until the register frees, without any change to the allocator state.
// ----------------------------------------------------------------------------
module slab_free_list_allocator (
  input  logic   clk,
  input  logic   rst,
  sfla_req_if.sink   req,
  sfla_rsp_if.source rsp,
  sfla_cfg_if.sink   cfg
);
  import sfla_pkg::*;

  // Controller and request registers.
  state_t            state, state_next;
  cmd_t              cmd_q;
  logic [SLAB_W-1:0] slab_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLAB_W-1:0] cur_slab;
  logic [SLOT_W-1:0] sweep_idx;
  logic [CFG_W-1:0]  cfg_slots;

  // Per-slab state.
  logic [OPEN_W-1:0] open_slabs;
  logic [CNT_W-1:0]  slab_head [MAX_SLABS];
  logic [CNT_W-1:0]  slab_free_count [MAX_SLABS];

  // Link memory.
  logic [CNT_W-1:0]  link_mem [MAX_SLABS * MAX_SLOTS];
  logic [CNT_W-1:0]  rd_data;

  // Output register.
  logic              out_valid;
  status_t           out_status;
  logic [SLAB_W-1:0] out_slab;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_left;

  // Control produced by the output decode.
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              res_load;
  status_t           res_status;
  logic [SLAB_W-1:0] res_slab;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_left;
  logic              head_we, cnt_we, open_we, cur_load;
  logic [SLAB_W-1:0] upd_slab, cur_val;
  logic [CNT_W-1:0]  head_val, cnt_val;
  logic [OPEN_W-1:0] open_val;

  // Helper terms.
  logic [CNT_W-1:0]  eff_n;
  logic              out_free;
  logic              found;
  logic [SLAB_W-1:0] found_slab;
  logic              free_ok;
  logic              sweep_last, init_last;

  // Handshakes.
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || rsp.ready;

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.slab_index     = out_slab;
  assign rsp.slot_index     = out_slot;
  assign rsp.slab_free_left = out_left;

  // Effective slot count, clamped to 1..MAX_SLOTS.
  always_comb begin
    if (cfg_slots == '0) begin
      eff_n = CNT_W'(1);
    end else if (CNT_W'(cfg_slots) > CNT_W'(MAX_SLOTS)) begin
      eff_n = CNT_W'(MAX_SLOTS);
    end else begin
      eff_n = CNT_W'(cfg_slots);
    end
  end

  // Newest open slab with a free slot (priority pick, highest index wins).
  always_comb begin
    found      = 1'b0;
    found_slab = '0;
    for (int i = 0; i < MAX_SLABS; i++) begin
      if (OPEN_W'(i) < open_slabs && slab_free_count[i] != '0) begin
        found      = 1'b1;
        found_slab = SLAB_W'(i);
      end
    end
  end

  // Free bounds checks against the open slabs and the current slot count.
  assign free_ok = (OPEN_W'(slab_q) < open_slabs) && (CNT_W'(slot_q) < eff_n) &&
                   (slab_free_count[slab_q] < eff_n);

  assign sweep_last = (CNT_W'(sweep_idx) == eff_n - CNT_W'(1));
  assign init_last  = (sweep_idx == SLOT_W'(MAX_SLOTS - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (cmd_q == CMD_ALLOC) begin
            if (found) begin
              state_next = S_POP;
            end else if (open_slabs >= OPEN_W'(MAX_SLABS)) begin
              state_next = S_IDLE;
            end else begin
              state_next = S_SWEEP;
            end
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        if (sweep_last) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_POP;
      end
      S_POP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control per state.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    res_load   = 1'b0;
    res_status = STAT_IGNORED;
    res_slab   = '0;
    res_slot   = '0;
    res_left   = '0;
    head_we    = 1'b0;
    cnt_we     = 1'b0;
    upd_slab   = cur_slab;
    head_val   = '0;
    cnt_val    = '0;
    open_we    = 1'b0;
    open_val   = open_slabs;
    cur_load   = 1'b0;
    cur_val    = cur_slab;
    case (state)
      S_INIT: begin
        // Slab 0 links: slot i points to i + 1.
        mem_we    = 1'b1;
        mem_waddr = {SLAB_W'(0), sweep_idx};
        mem_wdata = CNT_W'(sweep_idx) + CNT_W'(1);
      end
      S_EXEC: begin
        if (out_free) begin
          case (cmd_q)
            CMD_ALLOC: begin
              if (found) begin
                cur_load  = 1'b1;
                cur_val   = found_slab;
                mem_re    = 1'b1;
                mem_raddr = {found_slab, slab_head[found_slab][SLOT_W-1:0]};
              end else if (open_slabs >= OPEN_W'(MAX_SLABS)) begin
                res_load   = 1'b1;
                res_status = STAT_ALLOC_FAIL;
              end else begin
                cur_load = 1'b1;
                cur_val  = open_slabs[SLAB_W-1:0];
              end
            end
            CMD_FREE: begin
              res_load = 1'b1;
              if (free_ok) begin
                // Push the slot onto the head of its slab's list.
                mem_we     = 1'b1;
                mem_waddr  = {slab_q, slot_q};
                mem_wdata  = slab_head[slab_q];
                upd_slab   = slab_q;
                head_we    = 1'b1;
                head_val   = CNT_W'(slot_q);
                cnt_we     = 1'b1;
                cnt_val    = slab_free_count[slab_q] + CNT_W'(1);
                res_status = STAT_FREED;
                res_slab   = slab_q;
                res_slot   = slot_q;
                res_left   = slab_free_count[slab_q] + CNT_W'(1);
              end
            end
            CMD_DISCARD: begin
              res_load   = 1'b1;
              res_status = STAT_RESET_DONE;
              open_we    = 1'b1;
              open_val   = '0;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_SWEEP: begin
        // Fresh slab: write its links, then open it with the full count.
        mem_we    = 1'b1;
        mem_waddr = {cur_slab, sweep_idx};
        mem_wdata = CNT_W'(sweep_idx) + CNT_W'(1);
        if (sweep_last) begin
          head_we  = 1'b1;
          head_val = '0;
          cnt_we   = 1'b1;
          cnt_val  = eff_n;
          open_we  = 1'b1;
          open_val = open_slabs + OPEN_W'(1);
        end
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = {cur_slab, slab_head[cur_slab][SLOT_W-1:0]};
      end
      S_POP: begin
        if (out_free) begin
          // Pop the head slot; the link read gives the new head.
          head_we    = 1'b1;
          head_val   = rd_data;
          cnt_we     = 1'b1;
          cnt_val    = slab_free_count[cur_slab] - CNT_W'(1);
          res_load   = 1'b1;
          res_status = STAT_ALLOCATED;
          res_slab   = cur_slab;
          res_slot   = slab_head[cur_slab][SLOT_W-1:0];
          res_left   = slab_free_count[cur_slab] - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Controller registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep_idx <= '0;
      cfg_slots <= CFG_RESET;
      cur_slab  <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_SWEEP) begin
        sweep_idx <= sweep_idx + SLOT_W'(1);
      end else begin
        sweep_idx <= '0;
      end
      if (cfg.valid) cfg_slots <= cfg.slots_per_slab;
      if (cur_load) cur_slab <= cur_val;
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd_q  <= req.cmd;
      slab_q <= req.free_slab;
      slot_q <= req.free_slot;
    end
  end

  // Slab heads, free counts and the number of open slabs.
  always_ff @(posedge clk) begin
    if (rst) begin
      open_slabs <= OPEN_W'(1);
      for (int i = 0; i < MAX_SLABS; i++) begin
        slab_head[i]       <= '0;
        slab_free_count[i] <= '0;
      end
      slab_free_count[0] <= CNT_W'(MAX_SLOTS);
    end else begin
      if (open_we) open_slabs <= open_val;
      if (head_we) slab_head[upd_slab] <= head_val;
      if (cnt_we) slab_free_count[upd_slab] <= cnt_val;
    end
  end

  // Link memory write port.
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
  end

  // Link memory read port, registered.
  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= link_mem[mem_raddr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= res_status;
      out_slab   <= res_slab;
      out_slot   <= res_slot;
      out_left   <= res_left;
    end
  end

  // A new result only comes out of the final step of a request.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (state == S_EXEC || state == S_POP))
    else $error("result loaded outside a final step");

  // A pop always works on a slab that has a free slot.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> slab_free_count[cur_slab] != '0)
    else $error("pop from a slab without free slots");

  // The link memory is never read and written in the same cycle.
  a_mem_port: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("link memory read and write collide");

  // A held allocation result names a slab that is still open.
  a_alloc_open: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == STAT_ALLOCATED) |-> OPEN_W'(out_slab) < open_slabs)
    else $error("allocation result names a closed slab");

endmodule

// ===== test/slab_free_list_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// slab_free_list_allocator_checker
// Watches the request, response and configuration channels of the slab
// allocator. It keeps its own copy of the slab lists and counts, works out the
// result of every accepted request and compares each response with the oldest
// outstanding result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_free_list_allocator_checker (
  input  logic clk,
  input  logic rst,
  sfla_req_if  req,
  sfla_rsp_if  rsp,
  sfla_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);
  import sfla_pkg::*;

  // One response as the allocator should return it.
  typedef struct packed {
    status_t           status;
    logic [SLAB_W-1:0] slab;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  left;
  } outcome_t;

  outcome_t         awaited_results[$];

  // Shadow copy of the register and of the slab store.
  logic [CFG_W-1:0] slot_cfg;
  logic [OPEN_W-1:0] slabs_open;
  logic [CNT_W-1:0] head_slot [MAX_SLABS];
  logic [CNT_W-1:0] free_left [MAX_SLABS];
  logic [CNT_W-1:0] link_mem  [MAX_SLABS*MAX_SLOTS];

  // Slot count in force: the register clamped to 1..MAX_SLOTS.
  function automatic int active_slots();
    int n;
    n = int'(slot_cfg);
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  // A new slab lists its slots in ascending order, all of them free.
  function automatic void open_new_slab(input int s);
    int n;
    n = active_slots();
    for (int i = 0; i < n; i++) link_mem[s*MAX_SLOTS + i] = CNT_W'(i + 1);
    head_slot[s] = '0;
    free_left[s] = CNT_W'(n);
  endfunction

  // Applies one request to the shadow store and returns its response.
  function automatic outcome_t apply_request(input cmd_t op,
                                             input logic [SLAB_W-1:0] slab_in,
                                             input logic [SLOT_W-1:0] slot_in);
    outcome_t r;
    int       n;
    int       s;
    int       slot;
    bit       found;
    r        = '0;
    r.status = STAT_IGNORED;
    n        = active_slots();
    case (op)
      CMD_ALLOC: begin
        // Newest slab first; open another one only when all are full.
        found = 1'b0;
        s     = int'(slabs_open);
        while (s > 0) begin
          s--;
          if (free_left[s] > 0) begin
            found = 1'b1;
            break;
          end
        end
        if (!found) begin
          if (int'(slabs_open) >= MAX_SLABS) begin
            r.status = STAT_ALLOC_FAIL;
            return r;
          end
          s = int'(slabs_open);
          open_new_slab(s);
          slabs_open++;
        end
        slot         = int'(head_slot[s]) % MAX_SLOTS;
        head_slot[s] = link_mem[s*MAX_SLOTS + slot];
        free_left[s]--;
        r.status = STAT_ALLOCATED;
        r.slab   = SLAB_W'(s);
        r.slot   = SLOT_W'(slot);
        r.left   = free_left[s];
      end
      CMD_FREE: begin
        s    = int'(slab_in);
        slot = int'(slot_in);
        // Handles outside the open slabs or beyond the slot count, and frees
        // to a wholly free slab, leave the store untouched.
        if (s < int'(slabs_open) && slot < n && int'(free_left[s]) < n) begin
          link_mem[s*MAX_SLOTS + slot] = head_slot[s];
          head_slot[s] = CNT_W'(slot);
          free_left[s]++;
          r.status = STAT_FREED;
          r.slab   = SLAB_W'(s);
          r.slot   = SLOT_W'(slot);
          r.left   = free_left[s];
        end
      end
      CMD_DISCARD: begin
        slabs_open = '0;
        r.status   = STAT_RESET_DONE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string label, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, label, want_v, got_v);
      fail_count++;
    end
  endtask

  // Register writes, then responses, then new requests, all at the same edge.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      slot_cfg   = CFG_RESET;
      slabs_open = OPEN_W'(1);
      open_new_slab(0);
      awaited_results.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (cfg.valid && cfg.ready) slot_cfg = cfg.slots_per_slab;

      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: status expected none, actual %0d", $time, rsp.status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 8'(want.status), 8'(rsp.status));
          check_field("slab_index", 8'(want.slab), 8'(rsp.slab_index));
          check_field("slot_index", 8'(want.slot), 8'(rsp.slot_index));
          check_field("slab_free_left", 8'(want.left), 8'(rsp.slab_free_left));
        end
      end

      if (req.valid && req.ready)
        awaited_results.push_back(apply_request(req.cmd, req.free_slab, req.free_slot));

      pending <= awaited_results.size();
    end
  end

endmodule

// ===== test/slab_free_list_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// slab_free_list_allocator_tb
// Drives directed and random allocate, free and discard requests through the
// allocator under several slot counts, with bursty request traffic and a
// stalling response side. The checker beside the block predicts and compares
// every response; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_free_list_allocator_tb;
  import sfla_pkg::*;

  // The command code that the block must reject.
  localparam cmd_t CMD_UNKNOWN = cmd_t'(2'd3);

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   burst_left = 0;
  int   slot_plan [10] = '{127, 2, 1, 64, 5, 0, 9, 3, 33, 4};

  sfla_req_if req ();
  sfla_rsp_if rsp ();
  sfla_cfg_if cfg ();

  slab_free_list_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  slab_free_list_allocator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response side: each stretch follows one stall style of random length.
  initial begin
    int stall_style;
    int span;
    rsp.ready <= 1'b0;
    forever begin
      stall_style = $urandom_range(0, 3);
      span        = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        case (stall_style)
          0:       rsp.ready <= 1'b1;
          1:       rsp.ready <= ($urandom_range(0, 1) == 0);
          2:       rsp.ready <= ($urandom_range(0, 7) == 0);
          default: rsp.ready <= ~rsp.ready;
        endcase
      end
    end
  end

  // One request transaction; bursts of random length are separated by gaps.
  task automatic send_request(input cmd_t op, input int slab, input int slot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req.valid     <= 1'b1;
    req.cmd       <= op;
    req.free_slab <= SLAB_W'(slab);
    req.free_slot <= SLOT_W'(slot);
    do @(posedge clk); while (!req.ready);
  endtask

  // Stops sending and waits until every outstanding response has arrived.
  task automatic wait_until_idle();
    req.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_slot_count(input int value);
    wait_until_idle();
    cfg.valid          <= 1'b1;
    cfg.slots_per_slab <= CFG_W'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Random request mix; frees mostly name plausible handles.
  task automatic random_request(input int n_eff, input int alloc_pct);
    int pick;
    int slab;
    int slot;
    pick = $urandom_range(0, 99);
    if (pick < alloc_pct) begin
      send_request(CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
    end else if (pick < 98) begin
      if ($urandom_range(0, 3) != 0) begin
        slab = (n_eff <= 8) ? $urandom_range(0, 15) : $urandom_range(0, 1);
        slot = $urandom_range(0, n_eff - 1);
      end else begin
        slab = $urandom_range(0, 15);
        slot = $urandom_range(0, 63);
      end
      send_request(CMD_FREE, slab, slot);
    end else if (pick < 99) begin
      send_request(CMD_DISCARD, $urandom_range(0, 15), $urandom_range(0, 63));
    end else begin
      send_request(CMD_UNKNOWN, $urandom_range(0, 15), $urandom_range(0, 63));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int setting;
    int n_eff;
    req.valid          <= 1'b0;
    req.cmd            <= CMD_ALLOC;
    req.free_slab      <= '0;
    req.free_slot      <= '0;
    cfg.valid          <= 1'b0;
    cfg.slots_per_slab <= CFG_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset slot count: pops, frees at the slot limit, ignored frees, discard.
    send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_ALLOC, 15, 63);
    send_request(CMD_FREE, 0, 63);
    send_request(CMD_FREE, 15, 0);
    send_request(CMD_UNKNOWN, 15, 63);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_FREE, 0, 5);
    send_request(CMD_DISCARD, 0, 0);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_ALLOC, 0, 0);

    // Zero clamps to one slot per slab: fill every slab, then fail.
    write_slot_count(0);
    send_request(CMD_DISCARD, 0, 0);
    repeat (MAX_SLABS + 1) send_request(CMD_ALLOC, 0, 0);
    send_request(CMD_FREE, 15, 0);
    send_request(CMD_FREE, 3, 1);
    send_request(CMD_ALLOC, 0, 0);

    // Random phases, each under its own slot count and allocation bias.
    for (int phase = 0; phase < 11; phase++) begin
      setting = (phase == 10) ? $urandom_range(0, 127) : slot_plan[phase];
      n_eff   = (setting < 1) ? 1 : ((setting > MAX_SLOTS) ? MAX_SLOTS : setting);
      write_slot_count(setting);
      for (int k = 0; k < 60; k++) begin
        if (k == 30 && phase % 3 == 1) wait_until_idle();
        random_request(n_eff, (phase % 2 == 0) ? 70 : 45);
      end
    end

    wait_until_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("slab_free_list_allocator verification clean");
    else
      $display("slab_free_list_allocator verification failed");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8_000_000;
    $display("slab_free_list_allocator verification failed");
    $finish;
  end

endmodule
